// ===== sv/hcbp_pkg.sv =====
// Shared types and constants of the prefix-code bit packer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hcbp_pkg;

   // Request type codes
   localparam logic [1:0] REQ_WRITE  = 2'd0;
   localparam logic [1:0] REQ_ENCODE = 2'd1;
   localparam logic [1:0] REQ_FLUSH  = 2'd2;

   localparam int MAX_CODE_LEN = 32;
   localparam int CODE_CAP     = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
   localparam int DEF_NUM_SYMBOLS = 256;
   localparam int BYTE_BITS    = 8;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  symbol;
      logic [5:0]  code_length;
      logic [31:0] code_value;
   } hcbp_request_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_last;
      logic [3:0] pad_bits;
      logic       error;
   } hcbp_result_type;

   // Table write transfer: symbol is truncated to the table depth downstream
   typedef struct packed {
      logic       enable;
      logic [7:0] symbol;
      logic [5:0] length;
      logic [31:0] code;
   } hcbp_twr_type;

   typedef struct packed {
      logic [5:0]  length;
      logic [31:0] code;
   } hcbp_entry_type;

endpackage

// ===== sv/hcbp_code_table.sv =====
// Code table: one memory of code length and code bits per symbol, registered read,
// plus per-entry valid flops so unwritten entries read as length zero. Uses hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_code_table import hcbp_pkg::*; #(
   parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
   input  logic           clock,
   input  logic           reset,
   input  hcbp_twr_type   wr,
   input  logic           rd_enable,
   input  logic [7:0]     rd_symbol,
   output hcbp_entry_type rd_entry
);

   localparam int AddrWidth = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

   hcbp_entry_type table_mem [NUM_SYMBOLS];
   logic [NUM_SYMBOLS-1:0] valid_ff;
   hcbp_entry_type rd_entry_ff;
   logic           rd_hit_ff;

   logic [AddrWidth-1:0] wr_addr;
   logic [AddrWidth-1:0] rd_addr;

   assign wr_addr = wr.symbol[AddrWidth-1:0];
   assign rd_addr = rd_symbol[AddrWidth-1:0];

   always_ff @(posedge clock) begin
      if (wr.enable) begin
         table_mem[wr_addr] <= '{length: wr.length, code: wr.code};
      end
      if (rd_enable) begin
         rd_entry_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr.enable) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_enable) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_entry.length = rd_hit_ff ? rd_entry_ff.length : 6'd0;
   assign rd_entry.code   = rd_entry_ff.code;

endmodule

// ===== sv/hcbp_packer.sv =====
// Request sequencer and bit packer: decodes requests, drives the code table,
// merges code bits with pending bits and emits one byte per cycle. Uses hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_packer import hcbp_pkg::*; #(
   parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hcbp_request_type req_data,
   output hcbp_twr_type     tbl_wr,
   output logic             tbl_rd_enable,
   output logic [7:0]       tbl_rd_symbol,
   input  hcbp_entry_type   tbl_entry,
   output logic             rsp_valid,
   output hcbp_result_type  rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

   state_type       state_ff, state_in;
   logic [6:0]      pend_bits_ff, pend_bits_in;
   logic [2:0]      pend_cnt_ff, pend_cnt_in;
   logic [38:0]     acc_ff, acc_in;
   logic [5:0]      total_ff, total_in;
   logic            miss_ff, miss_in;
   logic            rsp_valid_ff, rsp_valid_in;
   hcbp_result_type rsp_ff, rsp_in;

   logic        accept;
   logic        in_range;
   logic [5:0]  len_sat;
   logic [32:0] code_mask;
   logic [31:0] code_bits;
   logic [38:0] merged;
   logic [5:0]  merged_total;
   logic [5:0]  remain;

   assign accept   = start && (state_ff == ST_IDLE);
   assign in_range = ({1'b0, req_data.symbol} < 9'(NUM_SYMBOLS));
   assign len_sat  = (req_data.code_length > 6'(CODE_CAP)) ? 6'(CODE_CAP)
                                                          : req_data.code_length;

   assign tbl_wr.enable = accept && (req_data.req_type == REQ_WRITE) && in_range;
   assign tbl_wr.symbol = req_data.symbol;
   assign tbl_wr.length = len_sat;
   assign tbl_wr.code   = req_data.code_value;
   assign tbl_rd_enable = accept && (req_data.req_type == REQ_ENCODE);
   assign tbl_rd_symbol = req_data.symbol;

   // Stored lengths never exceed 32, so the mask fits in 33 bits
   assign code_mask    = (33'd1 << tbl_entry.length) - 33'd1;
   assign code_bits    = tbl_entry.code & code_mask[31:0];
   assign merged       = {32'd0, pend_bits_ff} | ({7'd0, code_bits} << pend_cnt_ff);
   assign merged_total = {3'd0, pend_cnt_ff} + tbl_entry.length;
   assign remain       = total_ff - 6'(BYTE_BITS);

   always_comb begin
      state_in     = state_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      miss_in      = miss_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  REQ_ENCODE: begin
                     miss_in  = !in_range;
                     state_in = ST_LOOKUP;
                  end
                  REQ_FLUSH: begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{out_byte: {1'b0, pend_bits_ff}, is_last: 1'b1,
                                pad_bits: 4'(BYTE_BITS) - {1'b0, pend_cnt_ff},
                                error: 1'b0};
                     pend_bits_in = '0;
                     pend_cnt_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOOKUP: begin
            if (miss_ff || (tbl_entry.length == 6'd0)) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{out_byte: 8'd0, is_last: 1'b1, pad_bits: 4'd0, error: 1'b1};
               state_in = ST_IDLE;
            end else if (merged_total < 6'(BYTE_BITS)) begin
               // no byte completes; pending bits above the count are already zero
               pend_bits_in = merged[6:0];
               pend_cnt_in  = merged_total[2:0];
               state_in     = ST_IDLE;
            end else begin
               acc_in   = merged;
               total_in = merged_total;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{out_byte: acc_ff[7:0], is_last: (remain < 6'(BYTE_BITS)),
                       pad_bits: 4'd0, error: 1'b0};
            acc_in   = acc_ff >> BYTE_BITS;
            total_in = remain;
            if (remain < 6'(BYTE_BITS)) begin
               pend_bits_in = acc_ff[14:8];
               pend_cnt_in  = remain[2:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         miss_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         miss_ff      <= miss_in;
      end
      acc_ff   <= acc_in;
      total_ff <= total_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/huffman_code_bit_packer_core.sv =====
// Top level of the prefix-code bit packer: code table plus packing sequencer.
// Depends on hcbp_pkg, hcbp_code_table and hcbp_packer.
//
//  channel  | ports                 | transfer
//  ---------+-----------------------+------------------------------------
//  request  | start, busy, req_data | edge with start high and busy low
//  result   | rsp_valid, rsp_data   | every cycle rsp_valid is high
//
// Table write: busy stays low, no result.
// Flush: busy stays low, result in the following cycle.
// Encode: busy through the registered table read (ST_LOOKUP) and then ST_EMIT, n = 0..4
// bytes, where the byte shifter emits one byte per cycle; an unknown symbol
// gives an error result from ST_LOOKUP and no bytes.
// Reset clears the table valid flops at once; no clearing pass. Results cannot stall.
`timescale 1ns / 1ps

module huffman_code_bit_packer_core import hcbp_pkg::*; #(
   parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hcbp_request_type req_data,
   output logic             rsp_valid,
   output hcbp_result_type  rsp_data
);

   hcbp_twr_type   tbl_wr;
   logic           tbl_rd_enable;
   logic [7:0]     tbl_rd_symbol;
   hcbp_entry_type tbl_entry;

   hcbp_code_table #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_table (
      .clock     (clock),
      .reset     (reset),
      .wr        (tbl_wr),
      .rd_enable (tbl_rd_enable),
      .rd_symbol (tbl_rd_symbol),
      .rd_entry  (tbl_entry)
   );

   hcbp_packer #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_packer (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .tbl_wr        (tbl_wr),
      .tbl_rd_enable (tbl_rd_enable),
      .tbl_rd_symbol (tbl_rd_symbol),
      .tbl_entry     (tbl_entry),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data)
   );

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |->
         rsp_data.is_last && (rsp_data.out_byte == 8'd0) && (rsp_data.pad_bits == 4'd0))
      else $error("error result carries data");

   a_pad_only_on_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.pad_bits != 4'd0) |->
         rsp_data.is_last && !rsp_data.error && (rsp_data.pad_bits <= 4'd8))
      else $error("bad pad bit count");

   a_encode_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.req_type == REQ_ENCODE) |=> busy)
      else $error("encode transfer did not start the sequencer");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.req_type == REQ_WRITE) |=> !rsp_valid)
      else $error("table write produced a result");

endmodule
